@@ sv/stt_pkg.sv @@
// shared types and constants for the source text tokenizer
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_NUM,
        MODE_WORD,
        MODE_STR,
        MODE_LCMT,
        MODE_BCMT,
        MODE_BSTAR
    } scan_mode_t;

    localparam logic [5:0] K_PLUS    = 6'd0;
    localparam logic [5:0] K_MINUS   = 6'd1;
    localparam logic [5:0] K_STAR    = 6'd2;
    localparam logic [5:0] K_SLASH   = 6'd3;
    localparam logic [5:0] K_INT     = 6'd4;
    localparam logic [5:0] K_LET     = 6'd5;
    localparam logic [5:0] K_IDENT   = 6'd6;
    localparam logic [5:0] K_STRING  = 6'd7;
    localparam logic [5:0] K_EQ      = 6'd8;
    localparam logic [5:0] K_NE      = 6'd9;
    localparam logic [5:0] K_GT      = 6'd10;
    localparam logic [5:0] K_LT      = 6'd11;
    localparam logic [5:0] K_GE      = 6'd12;
    localparam logic [5:0] K_LE      = 6'd13;
    localparam logic [5:0] K_AND     = 6'd14;
    localparam logic [5:0] K_OR      = 6'd15;
    localparam logic [5:0] K_TRUE    = 6'd16;
    localparam logic [5:0] K_FALSE   = 6'd17;
    localparam logic [5:0] K_ASSIGN  = 6'd18;
    localparam logic [5:0] K_NOT     = 6'd19;
    localparam logic [5:0] K_NONE    = 6'd20;
    localparam logic [5:0] K_PRINT   = 6'd21;
    localparam logic [5:0] K_IF      = 6'd22;
    localparam logic [5:0] K_WHILE   = 6'd23;
    localparam logic [5:0] K_FOR     = 6'd24;
    localparam logic [5:0] K_ELSE    = 6'd25;
    localparam logic [5:0] K_SEMI    = 6'd26;
    localparam logic [5:0] K_LPAREN  = 6'd27;
    localparam logic [5:0] K_RPAREN  = 6'd28;
    localparam logic [5:0] K_LBRACE  = 6'd29;
    localparam logic [5:0] K_RBRACE  = 6'd30;
    localparam logic [5:0] K_NEWLINE = 6'd31;
    localparam logic [5:0] K_EOT     = 6'd32;
    localparam logic [5:0] K_ERROR   = 6'd33;

    // pending operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LT   = 3'd1;
    localparam logic [2:0] OP_GT   = 3'd2;
    localparam logic [2:0] OP_EQ   = 3'd3;
    localparam logic [2:0] OP_NOT  = 3'd4;
    localparam logic [2:0] OP_AND  = 3'd5;
    localparam logic [2:0] OP_OR   = 3'd6;
    localparam logic [2:0] OP_DIV  = 3'd7;

    localparam logic [30:0] INT_MAXV = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [31:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic [5:0] op_single(input logic [2:0] p);
        case (p)
            OP_LT:   return K_LT;
            OP_GT:   return K_GT;
            OP_EQ:   return K_ASSIGN;
            OP_NOT:  return K_NOT;
            OP_DIV:  return K_SLASH;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] op_double(input logic [2:0] p);
        case (p)
            OP_LT:   return K_LE;
            OP_GT:   return K_GE;
            OP_EQ:   return K_EQ;
            OP_NOT:  return K_NE;
            OP_AND:  return K_AND;
            default: return K_OR;
        endcase
    endfunction

    function automatic logic [7:0] op_second(input logic [2:0] p);
        case (p)
            OP_AND:  return 8'h26;
            OP_OR:   return 8'h7C;
            default: return 8'h3D;
        endcase
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        case (c)
            8'h3C:   return OP_LT;
            8'h3E:   return OP_GT;
            8'h3D:   return OP_EQ;
            8'h21:   return OP_NOT;
            8'h26:   return OP_AND;
            8'h7C:   return OP_OR;
            8'h2F:   return OP_DIV;
            default: return OP_NONE;
        endcase
    endfunction

    // keyword lookup on the packed prefix; returns identifier on miss
    function automatic logic [5:0] kw_lookup(input logic [39:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            3'd2: if (w == 40'h6966) k = K_IF;
            3'd3: begin
                if (w == 40'h666F72) k = K_FOR;
                else if (w == 40'h6C6574) k = K_LET;
            end
            3'd4: begin
                if (w == 40'h74727565) k = K_TRUE;
                else if (w == 40'h6E6F6E65) k = K_NONE;
                else if (w == 40'h656C7365) k = K_ELSE;
            end
            3'd5: begin
                if (w == 40'h66616C7365) k = K_FALSE;
                else if (w == 40'h7072696E74) k = K_PRINT;
                else if (w == 40'h7768696C65) k = K_WHILE;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

@@ sv/source_text_tokenizer_core.sv @@
// streaming source tokenizer, one byte per request
// tokens of a request are written into the token queue when it is accepted
// throughput: one request per cycle while the queue holds at most one token;
//   otherwise the input is held until the output drains the queue
// a token queue of four entries parts input from output
// reset clears scanner state, position, line count and the queue
module source_text_tokenizer_core
    import stt_pkg::*;
#(
    parameter int MAX_WORD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [30:0] int_value,
    output logic [31:0] start_pos,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    // scanner state
    scan_mode_t  mode_reg, mode_next;
    logic [2:0]  pop_reg, pop_next;
    logic [30:0] acc_reg, acc_next;
    logic [39:0] wpre_reg, wpre_next;
    logic [2:0]  wlen_reg, wlen_next;
    logic [31:0] tstart_reg, tstart_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [15:0] line_reg, line_next;
    logic        lastnl_reg, lastnl_next;
    logic [15:0] run_reg, run_next;

    // token queue, four entries
    token_t      q_reg [4];
    logic [1:0]  rd_reg, wr_reg;
    logic [2:0]  cnt_reg;

    // tokens produced by the current request
    token_t      tok [3];
    logic [1:0]  ntok;

    logic        accept, pop;
    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;
    // room for three tokens; a request gives at most two
    assign in_ready = (cnt_reg <= 3'd1);

    logic is_digit, is_alpha, is_ws;
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    assign is_ws    = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) ||
                      (ch == 8'h0C) || (ch == 8'h0D);

    // next accumulator for a digit: acc*10 + d saturated
    logic [34:0] acc_mul;
    assign acc_mul = {4'd0, acc_reg} * 35'd10 + {31'd0, ch[3:0] - 4'd0};

    logic [15:0] run_inc;
    assign run_inc = (run_reg == LEN_MAX) ? run_reg : run_reg + 16'd1;

    always_comb
    begin
        logic        consumed;
        logic        lnl;
        logic [15:0] ln;
        logic [5:0]  wk;
        mode_next   = mode_reg;
        pop_next    = pop_reg;
        acc_next    = acc_reg;
        wpre_next   = wpre_reg;
        wlen_next   = wlen_reg;
        tstart_next = tstart_reg;
        bpos_next   = bpos_reg + 32'd1;
        line_next   = line_reg;
        run_next    = run_reg;
        consumed    = 1'b0;
        lnl         = lastnl_reg;
        ln          = line_reg;
        ntok        = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            tok[i] = '0;
        end
        wk = (run_reg > 16'(MAX_WORD)) ? K_ERROR : kw_lookup(wpre_reg, wlen_reg);

        if (end_of_text)
        begin
            // flush pending then end-of-text
            unique case (mode_reg)
                MODE_OP:   begin tok[0] = '{op_single(pop_reg), '0, tstart_reg, 16'd1, ln, 1'b0}; ntok = 2'd1; end
                MODE_NUM:  begin tok[0] = '{K_INT, acc_reg, tstart_reg, run_reg, ln, 1'b0}; ntok = 2'd1; end
                MODE_WORD: begin tok[0] = '{wk, '0, tstart_reg, run_reg, ln, 1'b0}; ntok = 2'd1; end
                MODE_STR:  begin tok[0] = '{K_ERROR, '0, tstart_reg, run_reg, ln, 1'b0}; ntok = 2'd1; end
                default:   ntok = 2'd0;
            endcase
            tok[ntok] = '{K_EOT, '0, bpos_reg, 16'd0, ln, 1'b1};
            ntok = ntok + 2'd1;
            mode_next = MODE_IDLE; pop_next = OP_NONE; acc_next = '0; wpre_next = '0;
            wlen_next = '0; tstart_next = '0; bpos_next = '0; line_next = '0;
            lnl = 1'b0; run_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_OP:
                begin
                    mode_next = MODE_IDLE;
                    if (pop_reg == OP_DIV && ch == 8'h2F)
                    begin
                        mode_next = MODE_LCMT; consumed = 1'b1;
                    end
                    else if (pop_reg == OP_DIV && ch == 8'h2A)
                    begin
                        mode_next = MODE_BCMT; consumed = 1'b1;
                    end
                    else if (pop_reg != OP_DIV && ch == op_second(pop_reg))
                    begin
                        tok[0] = '{op_double(pop_reg), '0, tstart_reg, 16'd2, ln, 1'b0};
                        ntok = 2'd1; consumed = 1'b1;
                    end
                    else
                    begin
                        tok[0] = '{op_single(pop_reg), '0, tstart_reg, 16'd1, ln, 1'b0};
                        ntok = 2'd1;
                    end
                    pop_next = OP_NONE;
                end
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        acc_next = (acc_mul > {4'd0, INT_MAXV}) ? INT_MAXV : acc_mul[30:0];
                        run_next = run_inc; consumed = 1'b1;
                    end
                    else
                    begin
                        tok[0] = '{K_INT, acc_reg, tstart_reg, run_reg, ln, 1'b0};
                        ntok = 2'd1; mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD:
                begin
                    if (is_alpha)
                    begin
                        if (wlen_reg < 3'd5) wpre_next = {wpre_reg[31:0], ch};
                        if (wlen_reg < 3'd6) wlen_next = wlen_reg + 3'd1;
                        run_next = run_inc; consumed = 1'b1;
                    end
                    else
                    begin
                        tok[0] = '{wk, '0, tstart_reg, run_reg, ln, 1'b0};
                        ntok = 2'd1; mode_next = MODE_IDLE;
                    end
                end
                MODE_STR:
                begin
                    if (ch == 8'h22)
                    begin
                        tok[0] = '{K_STRING, '0, tstart_reg, run_reg, ln, 1'b0};
                        ntok = 2'd1; mode_next = MODE_IDLE; consumed = 1'b1;
                    end
                    else if (ch == 8'h0A)
                    begin
                        tok[0] = '{K_ERROR, '0, tstart_reg, run_reg, ln, 1'b0};
                        ntok = 2'd1; mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        run_next = run_inc; consumed = 1'b1;
                    end
                end
                MODE_LCMT:
                begin
                    if (ch == 8'h0A) mode_next = MODE_IDLE;
                    else consumed = 1'b1;
                end
                MODE_BCMT, MODE_BSTAR:
                begin
                    if (ch == 8'h0A) line_next = line_reg + 16'd1;
                    if (mode_reg == MODE_BSTAR && ch == 8'h2F) mode_next = MODE_IDLE;
                    else mode_next = (ch == 8'h2A) ? MODE_BSTAR : MODE_BCMT;
                    consumed = 1'b1;
                end
                default: mode_next = MODE_IDLE;
            endcase
            if (ntok != 2'd0) lnl = 1'b0;

            if (!consumed)
            begin
                if (ch == 8'h0A)
                begin
                    if (!lnl)
                    begin
                        tok[ntok] = '{K_NEWLINE, '0, bpos_reg, 16'd1, ln, 1'b0};
                        ntok = ntok + 2'd1;
                    end
                    lnl = 1'b1;
                    line_next = line_reg + 16'd1;
                end
                else if (is_ws)
                begin
                    lnl = lnl;
                end
                else if (ch == 8'h22)
                begin
                    mode_next = MODE_STR; tstart_next = bpos_reg + 32'd1; run_next = '0;
                end
                else if (op_code(ch) != OP_NONE)
                begin
                    mode_next = MODE_OP; pop_next = op_code(ch); tstart_next = bpos_reg;
                end
                else if (is_digit)
                begin
                    mode_next = MODE_NUM; acc_next = {27'd0, ch[3:0]};
                    tstart_next = bpos_reg; run_next = 16'd1;
                end
                else if (is_alpha)
                begin
                    mode_next = MODE_WORD; wpre_next = {32'd0, ch}; wlen_next = 3'd1;
                    tstart_next = bpos_reg; run_next = 16'd1;
                end
                else
                begin
                    case (ch)
                        8'h2B: tok[ntok].kind = K_PLUS;
                        8'h2D: tok[ntok].kind = K_MINUS;
                        8'h2A: tok[ntok].kind = K_STAR;
                        8'h3B: tok[ntok].kind = K_SEMI;
                        8'h28: tok[ntok].kind = K_LPAREN;
                        8'h29: tok[ntok].kind = K_RPAREN;
                        8'h7B: tok[ntok].kind = K_LBRACE;
                        8'h7D: tok[ntok].kind = K_RBRACE;
                        default: tok[ntok].kind = K_ERROR;
                    endcase
                    tok[ntok].start = bpos_reg;
                    tok[ntok].len   = 16'd1;
                    tok[ntok].line  = ln;
                    ntok = ntok + 2'd1;
                    lnl = 1'b0;
                end
            end
            if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
        end
        lastnl_next = lnl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pop_reg    <= OP_NONE;
            acc_reg    <= '0;
            wpre_reg   <= '0;
            wlen_reg   <= '0;
            tstart_reg <= '0;
            bpos_reg   <= '0;
            line_reg   <= '0;
            lastnl_reg <= 1'b0;
            run_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pop_reg    <= pop_next;
            acc_reg    <= acc_next;
            wpre_reg   <= wpre_next;
            wlen_reg   <= wlen_next;
            tstart_reg <= tstart_next;
            bpos_reg   <= bpos_next;
            line_reg   <= line_next;
            lastnl_reg <= lastnl_next;
            run_reg    <= run_next;
        end
    end

    // queue pointers and count
    logic [1:0] nwr;
    assign nwr = accept ? ntok : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (pop) rd_reg <= rd_reg + 2'd1;
            wr_reg  <= wr_reg + nwr;
            cnt_reg <= cnt_reg + {1'b0, nwr} - {2'd0, pop};
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < ntok) q_reg[wr_reg + 2'(i)] <= tok[i];
            end
        end
    end

    assign out_valid    = (cnt_reg != 3'd0);
    assign token_kind   = q_reg[rd_reg].kind;
    assign int_value    = q_reg[rd_reg].value;
    assign start_pos    = q_reg[rd_reg].start;
    assign token_length = q_reg[rd_reg].len;
    assign line_number  = q_reg[rd_reg].line;
    assign last_of_run  = q_reg[rd_reg].last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue overflow");
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= 3'd2 |-> !in_ready) else $error("accept without room");
    a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> bpos_reg == 32'd0 && mode_reg == MODE_IDLE)
        else $error("end of text did not reset");
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !end_of_text |=> bpos_reg == $past(bpos_reg) + 32'd1)
        else $error("position did not advance");
`endif

endmodule

@@ bench/source_text_tokenizer_core_tb.sv @@
// testbench for the source text tokenizer core: random and directed text against a local lexer model
`timescale 1ns / 1ps

module source_text_tokenizer_core_tb
    import stt_pkg::*;
();

    localparam int WORD_LIMIT = 64;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [30:0] int_value;
    logic [31:0] start_pos;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    source_text_tokenizer_core #(.MAX_WORD(WORD_LIMIT)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ch(ch), .end_of_text(end_of_text),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .int_value(int_value), .start_pos(start_pos),
        .token_length(token_length), .line_number(line_number),
        .last_of_run(last_of_run)
    );

    // pending requests: bit 8 is end of text, bits 7:0 the byte
    logic [8:0] byte_queue[$];
    token_t     token_queue[$];
    int         error_count = 0;
    bit         stimulus_done = 0;
    bit         calm_mode = 0;   // stretch with no idling
    bit         hold_go = 0;     // starts the long receiver hold-off
    bit         hold_active = 0; // receiver held off while set

    // lexer model state
    scan_mode_t   lx_mode;
    logic [2:0]   lx_op;
    logic [30:0]  lx_num;
    logic [39:0]  lx_prefix;
    logic [6:0]   lx_wlen;
    logic [31:0]  lx_start;
    logic [31:0]  lx_pos;
    logic [15:0]  lx_line;
    bit           lx_was_nl;
    logic [15:0]  lx_run;
    int           lx_count;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic lx_reset();
        lx_mode = MODE_IDLE; lx_op = OP_NONE; lx_num = '0; lx_prefix = '0;
        lx_wlen = '0; lx_start = '0; lx_pos = '0; lx_line = '0;
        lx_was_nl = 0; lx_run = '0;
    endtask

    task automatic push_token(logic [5:0] k, logic [30:0] v, logic [31:0] s, logic [15:0] n);
        token_t t;
        t.kind = k; t.value = v; t.start = s; t.len = n; t.line = lx_line; t.last = 0;
        token_queue.insert(token_queue.size(), t);
        lx_count++;
        lx_was_nl = (k == K_NEWLINE);
    endtask

    // keyword match written out independently of the package lookup
    task automatic push_word();
        logic [5:0] k;
        k = K_IDENT;
        if (lx_run > WORD_LIMIT) k = K_ERROR;
        else if (lx_wlen == 2 && lx_prefix == {24'd0, "if"}) k = K_IF;
        else if (lx_wlen == 3 && lx_prefix == {16'd0, "for"}) k = K_FOR;
        else if (lx_wlen == 3 && lx_prefix == {16'd0, "let"}) k = K_LET;
        else if (lx_wlen == 4 && lx_prefix == {8'd0, "true"}) k = K_TRUE;
        else if (lx_wlen == 4 && lx_prefix == {8'd0, "none"}) k = K_NONE;
        else if (lx_wlen == 4 && lx_prefix == {8'd0, "else"}) k = K_ELSE;
        else if (lx_wlen == 5 && lx_prefix == "false") k = K_FALSE;
        else if (lx_wlen == 5 && lx_prefix == "print") k = K_PRINT;
        else if (lx_wlen == 5 && lx_prefix == "while") k = K_WHILE;
        push_token(k, '0, lx_start, lx_run);
    endtask

    function automatic logic [5:0] single_kind(logic [2:0] p);
        case (p)
            OP_LT:   return K_LT;
            OP_GT:   return K_GT;
            OP_EQ:   return K_ASSIGN;
            OP_NOT:  return K_NOT;
            OP_DIV:  return K_SLASH;
            default: return K_ERROR;
        endcase
    endfunction

    task automatic flush_token();
        case (lx_mode)
            MODE_OP:   push_token(single_kind(lx_op), '0, lx_start, 16'd1);
            MODE_NUM:  push_token(K_INT, lx_num, lx_start, lx_run);
            MODE_WORD: push_word();
            MODE_STR:  push_token(K_ERROR, '0, lx_start, lx_run);
            default: ;
        endcase
        lx_mode = MODE_IDLE;
        lx_op = OP_NONE;
    endtask

    task automatic bump_run();
        if (lx_run != 16'hFFFF) lx_run++;
    endtask

    task automatic idle_scan(logic [7:0] c);
        case (c)
            8'h0A: begin
                if (!lx_was_nl) push_token(K_NEWLINE, '0, lx_pos, 16'd1);
                lx_line++;
            end
            8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
            "+": push_token(K_PLUS, '0, lx_pos, 16'd1);
            "-": push_token(K_MINUS, '0, lx_pos, 16'd1);
            "*": push_token(K_STAR, '0, lx_pos, 16'd1);
            ";": push_token(K_SEMI, '0, lx_pos, 16'd1);
            "(": push_token(K_LPAREN, '0, lx_pos, 16'd1);
            ")": push_token(K_RPAREN, '0, lx_pos, 16'd1);
            "{": push_token(K_LBRACE, '0, lx_pos, 16'd1);
            "}": push_token(K_RBRACE, '0, lx_pos, 16'd1);
            "\"": begin
                lx_mode = MODE_STR; lx_start = lx_pos + 1; lx_run = '0;
            end
            "<", ">", "=", "!", "&", "|", "/": begin
                lx_mode = MODE_OP; lx_start = lx_pos;
                case (c)
                    "<": lx_op = OP_LT;
                    ">": lx_op = OP_GT;
                    "=": lx_op = OP_EQ;
                    "!": lx_op = OP_NOT;
                    "&": lx_op = OP_AND;
                    "|": lx_op = OP_OR;
                    default: lx_op = OP_DIV;
                endcase
            end
            default: begin
                if (is_num(c)) begin
                    lx_mode = MODE_NUM; lx_num = 31'(c - "0");
                    lx_start = lx_pos; lx_run = 16'd1;
                end else if (is_letter(c)) begin
                    lx_mode = MODE_WORD; lx_prefix = {32'd0, c}; lx_wlen = 7'd1;
                    lx_start = lx_pos; lx_run = 16'd1;
                end else begin
                    push_token(K_ERROR, '0, lx_pos, 16'd1);
                end
            end
        endcase
    endtask

    // works out the tokens one request yields and queues them
    task automatic lex_request(logic [8:0] req);
        logic [7:0]  c;
        logic [7:0]  second;
        logic [5:0]  dbl;
        logic [33:0] prod;
        bit          taken;
        c = req[7:0];
        taken = 0;
        lx_count = 0;
        if (req[8]) begin
            flush_token();
            push_token(K_EOT, '0, lx_pos, 16'd0);
            token_queue[$].last = 1;
            lx_reset();
            return;
        end
        case (lx_mode)
            MODE_OP: begin
                case (lx_op)
                    OP_AND: begin second = "&"; dbl = K_AND; end
                    OP_OR:  begin second = "|"; dbl = K_OR; end
                    OP_LT:  begin second = "="; dbl = K_LE; end
                    OP_GT:  begin second = "="; dbl = K_GE; end
                    OP_EQ:  begin second = "="; dbl = K_EQ; end
                    default: begin second = "="; dbl = K_NE; end
                endcase
                lx_mode = MODE_IDLE;
                if (lx_op == OP_DIV && c == "/") begin
                    lx_mode = MODE_LCMT; taken = 1;
                end else if (lx_op == OP_DIV && c == "*") begin
                    lx_mode = MODE_BCMT; taken = 1;
                end else if (lx_op != OP_DIV && c == second) begin
                    push_token(dbl, '0, lx_start, 16'd2); taken = 1;
                end else begin
                    push_token(single_kind(lx_op), '0, lx_start, 16'd1);
                end
                lx_op = OP_NONE;
            end
            MODE_NUM: begin
                if (is_num(c)) begin
                    prod = 34'(lx_num) * 10 + 34'(c - "0");
                    lx_num = (prod > 34'h7FFF_FFFF) ? INT_MAXV : prod[30:0];
                    bump_run(); taken = 1;
                end else flush_token();
            end
            MODE_WORD: begin
                if (is_letter(c)) begin
                    if (lx_wlen < 5) lx_prefix = {lx_prefix[31:0], c};
                    if (lx_wlen < 6) lx_wlen++;
                    bump_run(); taken = 1;
                end else flush_token();
            end
            MODE_STR: begin
                if (c == "\"") begin
                    push_token(K_STRING, '0, lx_start, lx_run);
                    lx_mode = MODE_IDLE; taken = 1;
                end else if (c == 8'h0A) flush_token();
                else begin
                    bump_run(); taken = 1;
                end
            end
            MODE_LCMT: begin
                if (c == 8'h0A) lx_mode = MODE_IDLE;
                else taken = 1;
            end
            MODE_BCMT, MODE_BSTAR: begin
                if (c == 8'h0A) lx_line++;
                if (lx_mode == MODE_BSTAR && c == "/") lx_mode = MODE_IDLE;
                else lx_mode = (c == "*") ? MODE_BSTAR : MODE_BCMT;
                taken = 1;
            end
            default: lx_mode = MODE_IDLE;
        endcase
        if (!taken) idle_scan(c);
        lx_pos++;
        if (lx_count > 0) token_queue[$].last = 1;
    endtask

    // stimulus helpers
    task automatic queue_byte(logic [8:0] b);
        byte_queue.insert(byte_queue.size(), b);
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte({1'b0, s[i]});
    endtask

    task automatic queue_end();
        queue_byte({1'b1, 8'($urandom)});
    endtask

    function automatic string random_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)))};
        return s;
    endfunction

    // one random fragment of mostly well-formed source
    task automatic queue_fragment();
        string kw[9] = '{"true", "false", "for", "print", "none", "if", "else", "let", "while"};
        string ops[20] = '{"+", "-", "*", ";", "(", ")", "{", "}", "<=", ">=", "==", "!=",
                           "&&", "||", "<", ">", "=", "!", "/", "&"};
        string s;
        case ($urandom_range(0, 11))
            0, 1: queue_text(kw[$urandom_range(0, 8)]);
            2:    queue_text(random_word($urandom_range(1, 7)));
            3, 4: queue_text(ops[$urandom_range(0, 19)]);
            5: begin
                s = "";
                for (int i = $urandom_range(1, 11); i > 0; i--)
                    s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
                queue_text(s);
            end
            6: begin
                s = "\"";
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    s = {s, string'(byte'($urandom_range(32, 126) == 34 ? 39 : $urandom_range(32, 126)))};
                queue_text({s, ($urandom_range(0, 4) == 0) ? "\n" : "\""});
            end
            7: queue_text($urandom_range(0, 1) ? "// note\n" : "/* a*b\n**/");
            8: queue_text($urandom_range(0, 1) ? "\n" : "\n\n");
            9: begin
                // noise: any byte at all
                queue_byte({1'b0, 8'($urandom)});
            end
            default: queue_text(" ");
        endcase
    endtask

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // driver: offers queued bytes, idles at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 0;
            ch          <= '0;
            end_of_text <= 0;
        end else begin
            if (in_valid && in_ready) lex_request({end_of_text, ch});
            if (!(in_valid && !in_ready)) begin
                if (byte_queue.size() > 0 && (calm_mode || $urandom_range(0, 99) >= 11)) begin
                    {end_of_text, ch} <= byte_queue.pop_front();
                    in_valid <= 1;
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_active = 1;
        repeat (60) @(posedge clk);
        hold_active = 0;
    end

    // monitor: accepts tokens and checks them in order
    always @(posedge clk or negedge rst_n) begin
        token_t exp_tok;
        if (!rst_n) begin
            out_ready <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (token_queue.size() == 0) begin
                    $display("%0t: unexpected token kind %0d", $time, token_kind);
                    error_count++;
                end else begin
                    exp_tok = token_queue.pop_front();
                    if (exp_tok.kind !== token_kind || exp_tok.value !== int_value ||
                        exp_tok.start !== start_pos || exp_tok.len !== token_length ||
                        exp_tok.line !== line_number || exp_tok.last !== last_of_run) begin
                        $display("%0t: expected kind %0d val %0d pos %0d len %0d line %0d last %0d",
                                 $time, exp_tok.kind, exp_tok.value, exp_tok.start, exp_tok.len,
                                 exp_tok.line, exp_tok.last);
                        $display("%0t: actual   kind %0d val %0d pos %0d len %0d line %0d last %0d",
                                 $time, token_kind, int_value, start_pos, token_length,
                                 line_number, last_of_run);
                        error_count++;
                    end
                end
            end
            if (hold_active) begin
                out_ready <= 0;
            end else begin
                out_ready <= calm_mode || $urandom_range(0, 99) >= 11;
            end
        end
    end

    initial begin
        // directed: operators, keywords, numbers, strings, comments, errors
        queue_text("+-*;(){}<=>===!=&&||< > = ! & | / @");
        queue_byte({1'b0, 8'h00});
        queue_byte({1'b0, 8'hFF});
        queue_end();
        queue_text("true false for print none if else let while whilex Zz\n\n\n");
        queue_text("0 007 99999999999 \"ab\" \"open\n");
        queue_text("// skip\nx/* a\n*/*/y");
        queue_text({random_word(70), " "});
        queue_text("\"unterminated");
        queue_end();
        queue_text("/* open");
        queue_end();
        queue_text("12");
        queue_end();
        // random text, ending each chunk with end of text now and then
        while (byte_queue.size() < 330) begin
            queue_fragment();
            if ($urandom_range(0, 60) == 0) queue_end();
        end
        queue_end();
        // stretch without idling, then a long receiver hold-off under load
        wait (byte_queue.size() < 300);
        calm_mode = 1;
        wait (byte_queue.size() < 200);
        calm_mode = 0;
        @(posedge clk);
        hold_go = 1;
        wait (byte_queue.size() == 0);
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        @(posedge clk);
        wait (!in_valid && token_queue.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0 && token_queue.size() == 0)
            $display("source_text_tokenizer_core: match");
        else
            $display("source_text_tokenizer_core: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("source_text_tokenizer_core: mismatch");
        $finish;
    end

endmodule
